/* hdl/tut_pkg.sv */
// package with payload types, codes and helpers for the tally trigger check
`timescale 1ns / 1ps
package tut_pkg;

	localparam int FRAC_BITS = 24;
	localparam int WIDE_W    = 96;
	localparam int HALF_W    = 48;
	localparam int CNT_W     = 7;

	localparam logic [1:0] MET_OFF = 2'd0;
	localparam logic [1:0] MET_VAR = 2'd1;
	localparam logic [1:0] MET_STD = 2'd2;
	localparam logic [1:0] MET_REL = 2'd3;

	localparam logic [31:0] RATIO_ONE = 32'h0001_0000;
	localparam logic [31:0] RATIO_SAT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        first_row;
		logic        last_row;
		logic [47:0] sum_value;
		logic [63:0] sum_squares;
		logic [15:0] realizations;
		logic [1:0]  metric_kind;
		logic [31:0] limit_value;
		logic        skip_zero_mean;
		logic [9:0]  score_code;
		logic [23:0] tally_number;
	} row_t;

	typedef struct packed {
		logic [31:0] peak_ratio;
		logic        no_contribution;
		logic [23:0] worst_tally;
		logic [9:0]  worst_score;
		logic        all_satisfied;
	} result_t;

	typedef enum logic [2:0] {
		OP_DIV  = 3'b001,
		OP_SQRT = 3'b010,
		OP_MUL  = 3'b100
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_req_t;

	function automatic logic [31:0] sat32(input logic [WIDE_W-1:0] x);
		logic [31:0] r;
		r = (x[WIDE_W-1:32] != '0) ? RATIO_SAT : x[31:0];
		return r;
	endfunction

endpackage

/* hdl/tut_unit.sv */
// shared iterative divide, square root and multiply unit
`timescale 1ns / 1ps
module tut_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tut_pkg::unit_req_t           req,
	input  logic [tut_pkg::WIDE_W-1:0]   a,
	input  logic [tut_pkg::HALF_W-1:0]   b,
	output logic                         done,
	output logic [tut_pkg::WIDE_W-1:0]   result
);
	import tut_pkg::*;

	op_t                op_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WIDE_W-1:0]  num_q;
	logic [WIDE_W-1:0]  acc_q;
	logic [49:0]        rem_q;
	logic [HALF_W-1:0]  root_q;
	logic [HALF_W-1:0]  b_q;

	logic [51:0] sub_a;
	logic [51:0] sub_b;
	logic [52:0] diff;
	logic        ge;

	always_comb begin
		unique case (op_q)
			OP_SQRT: begin
				sub_a = {rem_q, num_q[WIDE_W-1 -: 2]};
				sub_b = {2'b00, root_q, 2'b01};
			end
			default: begin
				sub_a = {3'b000, rem_q[HALF_W-1:0], num_q[WIDE_W-1]};
				sub_b = {4'b0000, b_q};
			end
		endcase
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = !diff[52];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					op_q   <= req.op;
					b_q    <= b;
					rem_q  <= '0;
					root_q <= '0;
					acc_q  <= '0;
					if (req.op == OP_MUL) begin
						num_q <= {a[HALF_W-1:0], {HALF_W{1'b0}}};
						cnt_q <= CNT_W'(HALF_W);
					end else if (req.op == OP_SQRT) begin
						num_q <= a;
						cnt_q <= CNT_W'(HALF_W);
					end else begin
						num_q <= a;
						cnt_q <= CNT_W'(WIDE_W);
					end
				end
			end else begin
				unique case (op_q)
					OP_DIV: begin
						rem_q <= {2'b00, ge ? diff[HALF_W-1:0] : sub_a[HALF_W-1:0]};
						num_q <= {num_q[WIDE_W-2:0], ge};
					end
					OP_SQRT: begin
						rem_q  <= ge ? diff[49:0] : sub_a[49:0];
						root_q <= {root_q[HALF_W-2:0], ge};
						num_q  <= {num_q[WIDE_W-3:0], 2'b00};
					end
					OP_MUL: begin
						acc_q <= {acc_q[WIDE_W-2:0], 1'b0}
							+ (num_q[WIDE_W-1] ? {{HALF_W{1'b0}}, b_q} : '0);
						num_q <= {num_q[WIDE_W-2:0], 1'b0};
					end
					default: begin
						num_q <= num_q;
					end
				endcase
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		unique case (op_q)
			OP_SQRT: result = {{HALF_W{1'b0}}, root_q};
			OP_MUL:  result = acc_q;
			default: result = num_q;
		endcase
	end

	assign done = done_q;

endmodule

/* hdl/tally_uncertainty_trigger_max_top.sv */
// top level: row sequencer, running maximum and result register
// work per row: a skipped row is handled in the idle state; a scored row runs three to five
// divisions, at most one square root and a square on the single shared unit; the result
// follows the last row's work
// throughput: one row at a time, src_stall is high until the row is done
// reset: arst_n clears the sequencer, the running maximum and the result valid
`timescale 1ns / 1ps
module tally_uncertainty_trigger_max_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  tut_pkg::row_t     src_data,
	output logic              res_valid,
	input  logic              res_stall,
	output tut_pkg::result_t  res_data
);
	import tut_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_MEAN   = 13'b0000000000010,
		ST_QMEAN  = 13'b0000000000100,
		ST_SQUARE = 13'b0000000001000,
		ST_VAR    = 13'b0000000010000,
		ST_VRDIV  = 13'b0000000100000,
		ST_VRSQRT = 13'b0000001000000,
		ST_SDSQRT = 13'b0000010000000,
		ST_SRDIV  = 13'b0000100000000,
		ST_RELDIV = 13'b0001000000000,
		ST_RRDIV  = 13'b0010000000000,
		ST_UPDATE = 13'b0100000000000,
		ST_EMIT   = 13'b1000000000000
	} state_t;

	state_t             state_q;
	unit_req_t          req_q;
	logic [WIDE_W-1:0]  a_q;
	logic [HALF_W-1:0]  b_q;
	logic               done;
	logic [WIDE_W-1:0]  result;

	logic [47:0] mean_q;
	logic [63:0] qm_q;
	logic [15:0] n_q;
	logic [1:0]  kind_q;
	logic [31:0] limit_q;
	logic [9:0]  score_q;
	logic [23:0] tally_q;
	logic        last_q;
	logic [31:0] ratio_q;

	logic [31:0] best_ratio_q;
	logic [23:0] best_tally_q;
	logic [9:0]  best_score_q;
	logic        inf_q;
	logic        res_valid_q;
	result_t     res_q;

	logic [47:0]       mag;
	logic              inf_eff;
	logic [WIDE_W-1:0] m2;
	logic [63:0]       var_num;

	assign mag     = src_data.sum_value[47] ? (48'd0 - src_data.sum_value) : src_data.sum_value;
	assign inf_eff = src_data.first_row ? 1'b0 : inf_q;
	assign m2      = result >> FRAC_BITS;
	assign var_num = (m2 <= {32'd0, qm_q}) ? (qm_q - m2[63:0]) : 64'd0;

	tut_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.a      (a_q),
		.b      (b_q),
		.done   (done),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= '{start: 1'b0, op: OP_DIV};
			best_ratio_q <= '0;
			best_tally_q <= '0;
			best_score_q <= '0;
			inf_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end
			if (req_q.start) begin
				req_q.start <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (src_valid) begin
							n_q     <= src_data.realizations;
							kind_q  <= src_data.metric_kind;
							limit_q <= src_data.limit_value;
							score_q <= src_data.score_code;
							tally_q <= src_data.tally_number;
							last_q  <= src_data.last_row;
							if (!inf_eff && src_data.realizations >= 16'd2
									&& src_data.metric_kind != MET_OFF
									&& src_data.sum_value == '0
									&& !src_data.skip_zero_mean) begin
								inf_q        <= 1'b1;
								best_ratio_q <= RATIO_SAT;
								best_tally_q <= src_data.tally_number;
								best_score_q <= src_data.score_code;
							end else if (src_data.first_row) begin
								best_ratio_q <= '0;
								best_tally_q <= '0;
								best_score_q <= '0;
								inf_q        <= 1'b0;
							end
							if (inf_eff || src_data.realizations < 16'd2
									|| src_data.metric_kind == MET_OFF
									|| src_data.sum_value == '0) begin
								state_q <= src_data.last_row ? ST_EMIT : ST_IDLE;
							end else begin
								req_q   <= '{start: 1'b1, op: OP_DIV};
								a_q     <= {48'd0, mag};
								b_q     <= {32'd0, src_data.realizations};
								qm_q    <= src_data.sum_squares;
								state_q <= ST_MEAN;
							end
						end
					end
					ST_MEAN: begin
						if (done) begin
							mean_q  <= result[47:0];
							req_q   <= '{start: 1'b1, op: OP_DIV};
							a_q     <= {32'd0, qm_q};
							state_q <= ST_QMEAN;
						end
					end
					ST_QMEAN: begin
						if (done) begin
							qm_q    <= result[63:0];
							req_q   <= '{start: 1'b1, op: OP_MUL};
							a_q     <= {48'd0, mean_q};
							b_q     <= mean_q;
							state_q <= ST_SQUARE;
						end
					end
					ST_SQUARE: begin
						if (done) begin
							req_q   <= '{start: 1'b1, op: OP_DIV};
							a_q     <= {32'd0, var_num};
							b_q     <= {32'd0, n_q - 16'd1};
							state_q <= ST_VAR;
						end
					end
					ST_VAR: begin
						if (done) begin
							if (limit_q == '0) begin
								ratio_q <= RATIO_SAT;
								state_q <= ST_UPDATE;
							end else if (kind_q == MET_VAR) begin
								req_q   <= '{start: 1'b1, op: OP_DIV};
								a_q     <= {result[63:0], 32'd0};
								b_q     <= {16'd0, limit_q};
								state_q <= ST_VRDIV;
							end else begin
								req_q   <= '{start: 1'b1, op: OP_SQRT};
								a_q     <= {32'd0, result[63:0]} << FRAC_BITS;
								state_q <= ST_SDSQRT;
							end
						end
					end
					ST_VRDIV: begin
						if (done) begin
							req_q   <= '{start: 1'b1, op: OP_SQRT};
							a_q     <= result;
							state_q <= ST_VRSQRT;
						end
					end
					ST_VRSQRT: begin
						if (done) begin
							ratio_q <= sat32(result);
							state_q <= ST_UPDATE;
						end
					end
					ST_SDSQRT: begin
						if (done) begin
							if (kind_q == MET_STD) begin
								req_q   <= '{start: 1'b1, op: OP_DIV};
								a_q     <= {52'd0, result[43:0]} << 16;
								b_q     <= {16'd0, limit_q};
								state_q <= ST_SRDIV;
							end else if (mean_q == '0) begin
								ratio_q <= RATIO_SAT;
								state_q <= ST_UPDATE;
							end else begin
								req_q   <= '{start: 1'b1, op: OP_DIV};
								a_q     <= {52'd0, result[43:0]} << FRAC_BITS;
								b_q     <= mean_q;
								state_q <= ST_RELDIV;
							end
						end
					end
					ST_SRDIV: begin
						if (done) begin
							ratio_q <= sat32(result);
							state_q <= ST_UPDATE;
						end
					end
					ST_RELDIV: begin
						if (done) begin
							req_q   <= '{start: 1'b1, op: OP_DIV};
							a_q     <= result << 16;
							b_q     <= {16'd0, limit_q};
							state_q <= ST_RRDIV;
						end
					end
					ST_RRDIV: begin
						if (done) begin
							ratio_q <= sat32(result);
							state_q <= ST_UPDATE;
						end
					end
					ST_UPDATE: begin
						if (ratio_q > best_ratio_q) begin
							best_ratio_q <= ratio_q;
							best_tally_q <= tally_q;
							best_score_q <= score_q;
						end
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
					ST_EMIT: begin
						if (!res_valid_q || !res_stall) begin
							res_valid_q           <= 1'b1;
							res_q.peak_ratio      <= best_ratio_q;
							res_q.no_contribution <= inf_q;
							res_q.worst_tally     <= best_tally_q;
							res_q.worst_score     <= best_score_q;
							res_q.all_satisfied   <= !inf_q && (best_ratio_q <= RATIO_ONE);
							state_q               <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign src_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
